// File: hdl/ttdt_pkg.sv
// Package for the touch tap and double-tap qualifier.
// Holds the register map, field widths, reset values and the configuration struct.
// No dependencies.
package ttdt_pkg;

   // Coordinate width default, handed to the top level parameter.
   localparam int COORD_BITS_DEFAULT = 12;

   // Configuration register widths.
   localparam int RADIUS_BITS = 12;
   localparam int WINDOW_BITS = 8;
   localparam int RSQ_BITS    = 2 * RADIUS_BITS;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_ADDR_W  = 2;

   // Reset values of the configuration registers.
   localparam logic                   CIRCLE_RESET = 1'b0;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd16;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd20;
   localparam logic                   HALF_RESET   = 1'b0;
   localparam logic [RSQ_BITS-1:0]    RSQ_RESET    = 24'd256;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_RANGE_IS_CIRCLE = 2'd0,
      REG_TAP_RADIUS      = 2'd1,
      REG_WINDOW_FRAMES   = 2'd2,
      REG_HALF_RATE       = 2'd3
   } csr_reg_type;

   // Configuration as seen by the range checker.
   typedef struct packed {
      logic                   range_is_circle;
      logic [RADIUS_BITS-1:0] tap_radius;
      logic [RSQ_BITS-1:0]    radius_sq;
   } range_cfg_type;

endpackage

// File: hdl/ttdt_range_check.sv
// Range check of a second tap against the anchor of the first tap.
// Square check on the per-axis offsets or circular check on the squared distance.
// Depends on ttdt_pkg.
module ttdt_range_check #(
   parameter int COORD_BITS = ttdt_pkg::COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]  pos_x,
   input  logic [COORD_BITS-1:0]  pos_y,
   input  logic [COORD_BITS-1:0]  anchor_x,
   input  logic [COORD_BITS-1:0]  anchor_y,
   input  ttdt_pkg::range_cfg_type cfg,
   output logic                   in_range
);
   import ttdt_pkg::*;

   localparam int CMP_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = (SQ_W + 1 > RSQ_BITS) ? SQ_W + 1 : RSQ_BITS;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [SQ_W-1:0]       dx_sq;
   logic [SQ_W-1:0]       dy_sq;
   logic [SUM_W-1:0]      dist_sq;
   logic                  square_ok;
   logic                  circle_ok;

   always_comb begin
      dx = (pos_x >= anchor_x) ? pos_x - anchor_x : anchor_x - pos_x;
      dy = (pos_y >= anchor_y) ? pos_y - anchor_y : anchor_y - pos_y;
      dx_sq = SQ_W'(dx) * SQ_W'(dx);
      dy_sq = SQ_W'(dy) * SQ_W'(dy);
      dist_sq = SUM_W'(dx_sq) + SUM_W'(dy_sq);
      square_ok = (CMP_W'(dx) <= CMP_W'(cfg.tap_radius)) &&
                  (CMP_W'(dy) <= CMP_W'(cfg.tap_radius));
      circle_ok = dist_sq <= SUM_W'(cfg.radius_sq);
      in_range = cfg.range_is_circle ? circle_ok : square_ok;
   end

endmodule

// File: hdl/touch_tap_and_double_tap_qualifier.sv
// Top level of the touch tap and double-tap qualifier.
// A request passes the input register, then the result register, to its response.
// Throughput: one transaction per cycle; the input register and result register
// each advance whenever the result register is empty or being taken.
// Reset: synchronous, active high; clears control state, sets the evaluation phase to one
// and loads the register defaults (square range, radius 16, window 20, full rate).
// Depends on ttdt_pkg and ttdt_range_check.
module touch_tap_and_double_tap_qualifier #(
   parameter int COORD_BITS = ttdt_pkg::COORD_BITS_DEFAULT,
   parameter int REQ_W      = ((2 * COORD_BITS + 7) / 8) * 8,
   parameter int RSP_W      = ((4 * COORD_BITS + 6 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // pos_x, pos_y, zero fill
   input  logic                              req_tuser,  // touched
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hold, press_edge, release_edge, last_x, last_y, move_x, move_y, double_tap, zero fill
   output logic [RSP_W-1:0]                  rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [ttdt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ttdt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ttdt_pkg::*;

   localparam int MOVE_BITS = COORD_BITS + 1;
   localparam int RSP_USED  = 4 * COORD_BITS + 6;

   // Configuration registers. The squared radius follows the radius register in the next
   // cycle, which is well inside the idle time required around configuration writes.
   logic                   circle_ff, circle_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic                   half_ff, half_in;
   logic [RSQ_BITS-1:0]    rsq_ff;
   range_cfg_type          range_cfg;

   // Input register stage.
   logic                  in_valid_ff, in_valid_in;
   logic                  in_touched_ff;
   logic [COORD_BITS-1:0] in_x_ff;
   logic [COORD_BITS-1:0] in_y_ff;

   // Tracking state, updated when an item moves from the input stage to the result.
   logic                   prior_touched_ff, prior_touched_in;
   logic [COORD_BITS-1:0]  prior_x_ff, prior_y_ff;
   logic [COORD_BITS-1:0]  held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [COORD_BITS-1:0]  held_prev_x_ff, held_prev_x_in;
   logic [COORD_BITS-1:0]  held_prev_y_ff, held_prev_y_in;
   logic                   tap_pending_ff, tap_pending_in;
   logic [WINDOW_BITS-1:0] countdown_ff, countdown_in;
   logic [COORD_BITS-1:0]  anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic                   eval_phase_ff, eval_phase_in;
   logic                   tap_flag_ff, tap_flag_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_USED-1:0]   out_data_ff, out_data_in;

   logic                  advance;
   logic                  press;
   logic                  release_now;
   logic                  in_range;
   logic [MOVE_BITS-1:0]  move_x;
   logic [MOVE_BITS-1:0]  move_y;

   // The result register frees up when it is empty or its transaction completes;
   // the input stage then hands its item over, and may take a new one in the same cycle.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = RSP_W'(out_data_ff);

   assign range_cfg.range_is_circle = circle_ff;
   assign range_cfg.tap_radius      = radius_ff;
   assign range_cfg.radius_sq       = rsq_ff;

   // The range test always uses the current sample against the stored anchor; its
   // answer only matters when a second press meets an open window, and on a press
   // the held coordinates are the current sample.
   ttdt_range_check #(
      .COORD_BITS (COORD_BITS)
   ) u_range_check (
      .pos_x    (in_x_ff),
      .pos_y    (in_y_ff),
      .anchor_x (anchor_x_ff),
      .anchor_y (anchor_y_ff),
      .cfg      (range_cfg),
      .in_range (in_range)
   );

   // Configuration decode.
   always_comb begin
      circle_in = circle_ff;
      radius_in = radius_ff;
      window_in = window_ff;
      half_in   = half_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_RANGE_IS_CIRCLE: circle_in = csr_wdata[0];
            REG_TAP_RADIUS:      radius_in = csr_wdata[RADIUS_BITS-1:0];
            REG_WINDOW_FRAMES:   window_in = csr_wdata[WINDOW_BITS-1:0];
            REG_HALF_RATE:       half_in   = csr_wdata[0];
            default:             circle_in = circle_ff;
         endcase
      end
   end

   // Per-frame tracking and double-tap qualification.
   always_comb begin
      press       = in_touched_ff && !prior_touched_ff;
      release_now = !in_touched_ff && prior_touched_ff;

      held_x_in = in_touched_ff ? in_x_ff : held_x_ff;
      held_y_in = in_touched_ff ? in_y_ff : held_y_ff;
      held_prev_x_in = prior_touched_ff ? prior_x_ff : held_prev_x_ff;
      held_prev_y_in = prior_touched_ff ? prior_y_ff : held_prev_y_ff;
      prior_touched_in = in_touched_ff;

      // In half-rate mode the phase toggles each frame; otherwise every frame evaluates.
      eval_phase_in = half_ff ? !eval_phase_ff : 1'b1;

      tap_pending_in = tap_pending_ff;
      countdown_in   = countdown_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      tap_flag_in    = tap_flag_ff;
      if (eval_phase_in) begin
         tap_flag_in = 1'b0;
         // An open window counts down first and closes when the count runs out.
         if (tap_pending_ff) begin
            if (countdown_ff <= WINDOW_BITS'(1)) begin
               countdown_in   = '0;
               tap_pending_in = 1'b0;
            end else begin
               countdown_in = countdown_ff - WINDOW_BITS'(1);
            end
         end
         if (press) begin
            if (tap_pending_in) begin
               // A second press outside the range leaves the window open.
               if (in_range) begin
                  tap_flag_in    = 1'b1;
                  tap_pending_in = 1'b0;
               end
            end else begin
               tap_pending_in = 1'b1;
               countdown_in   = window_ff;
               anchor_x_in    = in_x_ff;
               anchor_y_in    = in_y_ff;
            end
         end
      end

      move_x = MOVE_BITS'(held_x_in) - MOVE_BITS'(held_prev_x_in);
      move_y = MOVE_BITS'(held_y_in) - MOVE_BITS'(held_prev_y_in);

      out_data_in = {tap_flag_in, move_y, move_x, held_y_in, held_x_in,
                     release_now, press, in_touched_ff};

      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         circle_ff        <= CIRCLE_RESET;
         radius_ff        <= RADIUS_RESET;
         window_ff        <= WINDOW_RESET;
         half_ff          <= HALF_RESET;
         rsq_ff           <= RSQ_RESET;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         prior_touched_ff <= 1'b0;
         prior_x_ff       <= '0;
         prior_y_ff       <= '0;
         held_x_ff        <= '0;
         held_y_ff        <= '0;
         held_prev_x_ff   <= '0;
         held_prev_y_ff   <= '0;
         tap_pending_ff   <= 1'b0;
         countdown_ff     <= '0;
         anchor_x_ff      <= '0;
         anchor_y_ff      <= '0;
         eval_phase_ff    <= 1'b1;
         tap_flag_ff      <= 1'b0;
      end else begin
         circle_ff    <= circle_in;
         radius_ff    <= radius_in;
         window_ff    <= window_in;
         half_ff      <= half_in;
         rsq_ff       <= RSQ_BITS'(radius_ff) * RSQ_BITS'(radius_ff);
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prior_touched_ff <= prior_touched_in;
            prior_x_ff       <= in_x_ff;
            prior_y_ff       <= in_y_ff;
            held_x_ff        <= held_x_in;
            held_y_ff        <= held_y_in;
            held_prev_x_ff   <= held_prev_x_in;
            held_prev_y_ff   <= held_prev_y_in;
            tap_pending_ff   <= tap_pending_in;
            countdown_ff     <= countdown_in;
            anchor_x_ff      <= anchor_x_in;
            anchor_y_ff      <= anchor_y_in;
            eval_phase_ff    <= eval_phase_in;
            tap_flag_ff      <= tap_flag_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_touched_ff <= req_tuser;
         in_x_ff       <= req_tdata[COORD_BITS-1:0];
         in_y_ff       <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // A double tap can only be raised by an evaluation while a first tap window was open;
   // on frames that are not evaluated the flag simply holds.
   a_tap_needs_window: assert property (@(posedge clock) disable iff (reset)
      advance && eval_phase_in && tap_flag_in |-> tap_pending_ff)
      else $error("double tap raised without an open first-tap window");

   // At full rate every frame evaluates, so the phase stays at one.
   a_full_rate_phase: assert property (@(posedge clock) disable iff (reset)
      advance && !half_ff |=> eval_phase_ff)
      else $error("evaluation phase cleared at full rate");

   // Reset leaves both pipeline stages empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// File: test/touch_tap_and_double_tap_qualifier_tb.sv
`timescale 1ns / 100ps
// Testbench for the touch tap and double-tap qualifier: directed and random touch samples.
// A scoreboard class predicts each frame report and checks it against the response stream.
// Depends on ttdt_pkg and the touch_tap_and_double_tap_qualifier top level.
module touch_tap_and_double_tap_qualifier_tb;
   import ttdt_pkg::*;

   localparam int COORD_W   = COORD_BITS_DEFAULT;
   localparam int REQ_W     = ((2 * COORD_W + 7) / 8) * 8;
   localparam int RSP_W     = ((4 * COORD_W + 6 + 7) / 8) * 8;
   localparam int FILL_W    = RSP_W - (4 * COORD_W + 6);
   localparam int MAX_COORD = (1 << COORD_W) - 1;
   // Generous bound on the whole run, in clock cycles.
   localparam int CYCLE_LIMIT = 400000;
   // Random items per configuration phase and number of random phases.
   localparam int PHASE_ITEMS = 100;
   localparam int PHASES      = 9;

   // One frame report as it sits on rsp_tdata; the last field is in the lowest bits.
   typedef struct packed {
      logic [FILL_W-1:0]  fill;
      logic               double_tap;
      logic [COORD_W:0]   move_y;
      logic [COORD_W:0]   move_x;
      logic [COORD_W-1:0] last_y;
      logic [COORD_W-1:0] last_x;
      logic               release_edge;
      logic               press_edge;
      logic               hold;
   } frame_report_type;

   // The scoreboard keeps its own copy of the qualifier state and of the
   // configuration registers. Every accepted sample produces exactly one
   // predicted report, which is matched in order against the responses.
   class gesture_scoreboard_type;
      // Configuration registers.
      logic               cfg_circle;
      logic [11:0]        cfg_radius;
      logic [7:0]         cfg_window;
      logic               cfg_half;
      // Qualifier state.
      logic               prior_touched;
      logic [COORD_W-1:0] prior_x, prior_y;
      logic [COORD_W-1:0] held_x, held_y;
      logic [COORD_W-1:0] held_prev_x, held_prev_y;
      logic               tap_pending;
      logic [8:0]         countdown;
      logic [COORD_W-1:0] anchor_x, anchor_y;
      logic               eval_phase;
      logic               tap_flag;
      frame_report_type   expected_reports[$];
      int                 mismatches;

      function new();
         cfg_circle    = CIRCLE_RESET;
         cfg_radius    = RADIUS_RESET;
         cfg_window    = WINDOW_RESET;
         cfg_half      = HALF_RESET;
         prior_touched = 1'b0;
         prior_x       = '0;
         prior_y       = '0;
         held_x        = '0;
         held_y        = '0;
         held_prev_x   = '0;
         held_prev_y   = '0;
         tap_pending   = 1'b0;
         countdown     = '0;
         anchor_x      = '0;
         anchor_y      = '0;
         eval_phase    = 1'b1;
         tap_flag      = 1'b0;
         mismatches    = 0;
      endfunction

      // Bits above a register's width are dropped, as the block does.
      function void set_register(csr_reg_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_RANGE_IS_CIRCLE: cfg_circle = value[0];
            REG_TAP_RADIUS:      cfg_radius = value[11:0];
            REG_WINDOW_FRAMES:   cfg_window = value[7:0];
            REG_HALF_RATE:       cfg_half   = value[0];
            default: ;
         endcase
      endfunction

      // Distance test of the latest touched point against the first-tap anchor.
      function bit second_tap_in_range();
         longint dx, dy, r;
         dx = (held_x >= anchor_x) ? longint'(held_x) - longint'(anchor_x)
                                   : longint'(anchor_x) - longint'(held_x);
         dy = (held_y >= anchor_y) ? longint'(held_y) - longint'(anchor_y)
                                   : longint'(anchor_y) - longint'(held_y);
         r  = longint'(cfg_radius);
         if (!cfg_circle) begin
            return (dx <= r) && (dy <= r);
         end
         return (dx * dx + dy * dy) <= (r * r);
      endfunction

      // One double-tap evaluation: the open window ages first, then a press
      // either completes a double tap or arms a new first tap.
      function void evaluate_taps(logic press);
         tap_flag = 1'b0;
         if (tap_pending) begin
            if (countdown <= 9'd1) begin
               countdown   = '0;
               tap_pending = 1'b0;
            end else begin
               countdown = countdown - 9'd1;
            end
         end
         if (press) begin
            if (tap_pending) begin
               if (second_tap_in_range()) begin
                  tap_flag    = 1'b1;
                  tap_pending = 1'b0;
               end
            end else begin
               tap_pending = 1'b1;
               countdown   = {1'b0, cfg_window};
               anchor_x    = held_x;
               anchor_y    = held_y;
            end
         end
      endfunction

      function void note_sample(logic touched, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         frame_report_type rep;
         logic             press, lift;
         press = touched && !prior_touched;
         lift  = !touched && prior_touched;
         if (touched) begin
            held_x = x;
            held_y = y;
         end
         if (prior_touched) begin
            held_prev_x = prior_x;
            held_prev_y = prior_y;
         end
         prior_touched = touched;
         prior_x       = x;
         prior_y       = y;
         if (cfg_half) begin
            eval_phase = ~eval_phase;
         end else begin
            eval_phase = 1'b1;
         end
         if (eval_phase) begin
            evaluate_taps(press);
         end
         rep              = '0;
         rep.hold         = touched;
         rep.press_edge   = press;
         rep.release_edge = lift;
         rep.last_x       = held_x;
         rep.last_y       = held_y;
         rep.move_x       = {1'b0, held_x} - {1'b0, held_prev_x};
         rep.move_y       = {1'b0, held_y} - {1'b0, held_prev_y};
         rep.double_tap   = tap_flag;
         expected_reports.push_back(rep);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
         end
      endtask

      task check_report(logic [RSP_W-1:0] data);
         frame_report_type got, want;
         got = frame_report_type'(data);
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("report 0x%0h arrived with none expected", data));
            return;
         end
         want = expected_reports.pop_front();
         compare_field("hold", 16'(got.hold), 16'(want.hold));
         compare_field("press_edge", 16'(got.press_edge), 16'(want.press_edge));
         compare_field("release_edge", 16'(got.release_edge), 16'(want.release_edge));
         compare_field("last_x", 16'(got.last_x), 16'(want.last_x));
         compare_field("last_y", 16'(got.last_y), 16'(want.last_y));
         compare_field("move_x", 16'(got.move_x), 16'(want.move_x));
         compare_field("move_y", 16'(got.move_y), 16'(want.move_y));
         compare_field("double_tap", 16'(got.double_tap), 16'(want.double_tap));
      endtask

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // pos_x, pos_y, zero fill
   logic                  req_tuser;   // touched
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // hold, press_edge, release_edge, last_x, last_y, move_x, move_y, double_tap, zero fill
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gesture_scoreboard_type sb;
   int                     cycles = 0;
   int                     samples_sent;
   bit                     no_idle;
   // Response-side stall pattern: the current level of rsp_tready and how
   // many more cycles it keeps that level.
   int                     ready_run = 0;
   logic                   ready_level = 1'b0;

   touch_tap_and_double_tap_qualifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // The result side holds ready at a level for a random run of cycles. Most
   // stalls are short, a few are long, and some ready runs are long enough
   // that the block streams with no back-pressure at all.
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_level = ~ready_level;
         if (ready_level) begin
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
         end else begin
            ready_run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end
      end
      ready_run = ready_run - 1;
      rsp_tready <= ready_level;
   end

   // Both channels are watched in one process so that a sample is always
   // noted before any response of the same clock edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tuser, req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_report(rsp_tdata);
         end
      end
   end

   // Idle cycles ahead of a sample: mostly none or a few, now and then a long pause.
   function automatic int pick_gap();
      int roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   // Presents one touch sample and returns at the edge where it is taken.
   // tvalid stays high into the next call when no gap follows.
   task automatic send_sample(input logic touched, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= touched;
      req_tdata  <= {{(REQ_W - 2 * COORD_W){1'b0}}, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   function automatic logic [COORD_W-1:0] random_coord();
      return COORD_W'($urandom_range(0, MAX_COORD));
   endfunction

   // Moves a coordinate by an offset and clips it to the panel.
   function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base, int offset);
      int v;
      v = int'(base) + offset;
      if (v < 0) begin
         v = 0;
      end
      if (v > MAX_COORD) begin
         v = MAX_COORD;
      end
      return COORD_W'(v);
   endfunction

   // Offset of a second tap from the anchor, clustered on the range boundary.
   function automatic int tap_offset(int radius);
      int d;
      case ($urandom_range(0, 4))
         0: d = radius;
         1: d = radius + 1;
         2: d = $urandom_range(0, radius + 1);
         3: d = 0;
         default: d = (radius * 7) / 10;
      endcase
      return $urandom_range(0, 1) ? d : -d;
   endfunction

   // Lets the block drain: no transaction in flight, then idle time before the registers change.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type index, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] circle,
                               input logic [CSR_DATA_W-1:0] radius,
                               input logic [CSR_DATA_W-1:0] window,
                               input logic [CSR_DATA_W-1:0] half);
      write_csr(REG_RANGE_IS_CIRCLE, circle);
      write_csr(REG_TAP_RADIUS, radius);
      write_csr(REG_WINDOW_FRAMES, window);
      write_csr(REG_HALF_RATE, half);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // A well-formed double-tap attempt: a first press held for a few frames,
   // a lift, then a second press placed around the edge of the tap range.
   task automatic send_tap_pair();
      logic [COORD_W-1:0] ax, ay;
      int                 radius, lift_max;
      ax       = random_coord();
      ay       = random_coord();
      radius   = int'(sb.cfg_radius);
      lift_max = int'(sb.cfg_window) + 3;
      if (lift_max > 20) begin
         lift_max = 20;
      end
      send_sample(1'b1, ax, ay);
      repeat ($urandom_range(0, 2)) begin
         send_sample(1'b1, nudge(ax, $urandom_range(0, 6) - 3), nudge(ay, $urandom_range(0, 6) - 3));
      end
      repeat ($urandom_range(1, lift_max)) send_sample(1'b0, random_coord(), random_coord());
      send_sample(1'b1, nudge(ax, tap_offset(radius)), nudge(ay, tap_offset(radius)));
      repeat ($urandom_range(0, 2)) send_sample(1'b1, random_coord(), random_coord());
      repeat ($urandom_range(1, 2)) send_sample(1'b0, random_coord(), random_coord());
   endtask

   // Unstructured frames: random touch flag and coordinates over the full range.
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         send_sample(1'($urandom_range(0, 1)), random_coord(), random_coord());
      end
   endtask

   initial begin
      int                    first_sample;
      logic [CSR_DATA_W-1:0] circle, radius, window, half;
      sb           = new();
      samples_sent = 0;
      no_idle      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_RANGE_IS_CIRCLE;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset configuration: square range of 16,
      // window of 20, full rate.
      send_sample(1'b0, 12'd0, 12'd0);
      send_sample(1'b1, 12'd0, 12'd0);          // first press arms the window at the origin
      send_sample(1'b1, 12'd4095, 12'd4095);    // largest positive movement
      send_sample(1'b0, 12'd4095, 12'd4095);    // release
      send_sample(1'b1, 12'd10, 12'd16);        // second press on the square edge: double tap
      send_sample(1'b0, 12'd0, 12'd0);
      send_sample(1'b1, 12'd100, 12'd100);      // new first press
      send_sample(1'b0, 12'd2222, 12'd1111);
      send_sample(1'b1, 12'd117, 12'd100);      // just outside the range, window stays open
      send_sample(1'b0, 12'd0, 12'd4095);
      send_sample(1'b1, 12'd116, 12'd84);       // inside again: double tap
      send_sample(1'b1, 12'd4095, 12'd4095);
      send_sample(1'b1, 12'd0, 12'd0);          // largest negative movement
      send_sample(1'b0, 12'd4095, 12'd0);       // untouched coordinates are ignored

      // Directed frames on a circular range of 5 with a three-frame window.
      wait_idle();
      write_config(12'd1, 12'd5, 12'd3, 12'd0);
      send_sample(1'b1, 12'd50, 12'd50);        // arm
      send_sample(1'b0, 12'd0, 12'd0);
      send_sample(1'b1, 12'd54, 12'd54);        // inside the square, outside the circle
      send_sample(1'b0, 12'd0, 12'd0);          // window expires here
      send_sample(1'b1, 12'd53, 12'd54);        // press after expiry arms a new first tap
      send_sample(1'b0, 12'd0, 12'd0);
      send_sample(1'b1, 12'd50, 12'd50);        // distance exactly 5: double tap
      send_sample(1'b0, 12'd0, 12'd0);

      // Random phases. The first four pin the register extremes; the rest
      // draw settings at random, with stray upper bits in the write data.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               circle = 12'd0; radius = 12'd0; window = 12'd0; half = 12'd0;
            end
            1: begin
               circle = 12'd1; radius = 12'd4095; window = 12'd255; half = 12'd1;
            end
            2: begin
               circle = 12'd1; radius = 12'd0; window = 12'd1; half = 12'd0;
            end
            3: begin
               circle = 12'd0; radius = 12'd4095; window = 12'd2; half = 12'd1;
            end
            default: begin
               circle = {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))};
               radius = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                    : 12'($urandom_range(1, 40));
               window = {4'($urandom_range(0, 15)),
                         ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 15))};
               half   = {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))};
            end
         endcase
         write_config(circle, radius, window, half);
         first_sample = samples_sent;
         while (samples_sent - first_sample < PHASE_ITEMS) begin
            no_idle = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 7) begin
               send_tap_pair();
            end else begin
               send_noise();
            end
         end
         no_idle = 1'b0;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: touch_tap_and_double_tap_qualifier.f
hdl/ttdt_pkg.sv
hdl/ttdt_range_check.sv
hdl/touch_tap_and_double_tap_qualifier.sv
test/touch_tap_and_double_tap_qualifier_tb.sv
